// ----- hw/rtl/mme_pkg.sv -----
// Package for the min/max envelope decimator.
// Holds widths, register codes and the structs shared by all modules.
// No dependencies.
package mme_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int LEN_BITS    = 16;
	localparam int DATA_BITS   = 32;
	localparam int ADDR_BITS   = 3;

	// Compare width for window_count + 1 against window_len.
	localparam int CMP_BITS = (COUNT_BITS + 1 > LEN_BITS) ? COUNT_BITS + 1 : LEN_BITS;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Register index, taken from paddr bit 2.
	typedef enum logic {
		REG_PASSTHROUGH = 1'b0,
		REG_WINDOW_LEN  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic                passthrough;
		logic [LEN_BITS-1:0] window_len;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]         x_coord;
		logic signed [SAMPLE_BITS-1:0] value;
		logic                          event_mark;
		logic                          last;
	} result_t;

	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t res0;
		result_t res1;
	} push_t;

endpackage

// ----- hw/rtl/mme_regs.sv -----
// Configuration registers of the min/max envelope decimator, APB-style port.
// Depends on mme_pkg.
module mme_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mme_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mme_pkg::DATA_BITS-1:0] pwdata,
	output logic [mme_pkg::DATA_BITS-1:0] prdata,
	output logic                         pready,
	output mme_pkg::cfg_t                cfg
);
	import mme_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.passthrough <= 1'b1;
			cfg_q.window_len  <= LEN_BITS'(2);
		end else if (wr_en) begin
			unique case (idx)
				REG_PASSTHROUGH: cfg_q.passthrough <= pwdata[0];
				REG_WINDOW_LEN:  cfg_q.window_len  <= pwdata[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PASSTHROUGH: prdata = DATA_BITS'(cfg_q.passthrough);
			REG_WINDOW_LEN:  prdata = DATA_BITS'(cfg_q.window_len);
			default: prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/mme_fold.sv -----
// Envelope state and per-sample fold logic: running max/min, sticky event,
// window and x counters; produces zero, one or two results per transaction.
// Depends on mme_pkg.
module mme_fold (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mme_pkg::cfg_t                       cfg,
	input  logic                                accept,
	input  logic signed [mme_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                event_req,
	input  logic                                start_req,
	output mme_pkg::push_t                      push
);
	import mme_pkg::*;

	logic signed [SAMPLE_BITS-1:0] max_q, min_q;
	logic [COUNT_BITS-1:0]         wc_q, x_q;
	logic                          ev_q;

	logic signed [SAMPLE_BITS-1:0] base_max, base_min, new_max, new_min;
	logic [COUNT_BITS-1:0]         base_wc, x0;
	logic                          base_ev, new_ev;
	logic [CMP_BITS-1:0]           wc_inc;
	logic                          close;

	always_comb begin
		// A start request clears the window and the x count before the sample.
		base_max = start_req ? SAMPLE_MIN : max_q;
		base_min = start_req ? SAMPLE_MAX : min_q;
		base_wc  = start_req ? '0 : wc_q;
		base_ev  = start_req ? 1'b0 : ev_q;
		x0       = start_req ? '0 : x_q;

		new_max = (sample > base_max) ? sample : base_max;
		new_min = (sample < base_min) ? sample : base_min;
		new_ev  = base_ev || event_req;
		wc_inc  = CMP_BITS'(base_wc) + CMP_BITS'(1);
		close   = wc_inc >= CMP_BITS'(cfg.window_len);

		push.push0 = accept && (cfg.passthrough || close);
		push.push1 = accept && !cfg.passthrough && close;

		if (cfg.passthrough) begin
			push.res0 = '{x_coord: x0, value: sample, event_mark: event_req, last: 1'b1};
		end else begin
			push.res0 = '{x_coord: x0, value: new_max, event_mark: new_ev, last: 1'b0};
		end
		push.res1 = '{x_coord: x0 + COUNT_BITS'(1), value: new_min, event_mark: 1'b0,
			last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= SAMPLE_MIN;
			min_q <= SAMPLE_MAX;
			wc_q  <= '0;
			ev_q  <= 1'b0;
			x_q   <= '0;
		end else if (accept) begin
			if (cfg.passthrough) begin
				max_q <= base_max;
				min_q <= base_min;
				wc_q  <= base_wc;
				ev_q  <= base_ev;
				x_q   <= x0 + COUNT_BITS'(1);
			end else if (close) begin
				max_q <= SAMPLE_MIN;
				min_q <= SAMPLE_MAX;
				wc_q  <= '0;
				ev_q  <= 1'b0;
				x_q   <= x0 + COUNT_BITS'(2);
			end else begin
				max_q <= new_max;
				min_q <= new_min;
				wc_q  <= wc_inc[COUNT_BITS-1:0];
				ev_q  <= new_ev;
				x_q   <= x0;
			end
		end
	end

endmodule

// ----- hw/rtl/mme_outq.sv -----
// Result queue of the min/max envelope decimator: four entries, up to two
// writes and one read per cycle; input ready comes from a registered count.
// Depends on mme_pkg.
module mme_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  mme_pkg::push_t   push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output mme_pkg::result_t head
);
	import mme_pkg::*;

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q, wr_next;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign wr_next   = wr_q + QPTR_W'(1);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	// Room for a full pair of results, so no transaction can overrun the queue.
	assign room      = (cnt_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (push.push0 && (wr_q == QPTR_W'(i))) begin
				mem_q[i] <= push.res0;
			end else if (push.push1 && (wr_next == QPTR_W'(i))) begin
				mem_q[i] <= push.res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.push0) + QPTR_W'(push.push1);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.push0) + QCNT_W'(push.push1) - QCNT_W'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count above depth");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result written without the first");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> !push.push0)
		else $error("result written while the queue had no room");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		##1 cnt_q == $past(cnt_q) + QCNT_W'($past(push.push0)) + QCNT_W'($past(push.push1))
			- QCNT_W'($past(pop)))
		else $error("result queue count lost track");

endmodule

// ----- hw/rtl/min_max_envelope_decimator.sv -----
// Top level of the min/max envelope decimator.
// Depends on mme_pkg, mme_regs, mme_fold and mme_outq.
//
//   Channel  Signals                                   Direction
//   in       in_valid/in_ready, sample, event/start    input samples
//   out      out_valid/out_ready, x_coord, value, ...   result items
//   cfg      psel/penable/pwrite/paddr/pwdata/prdata   register access
//
// One sample is accepted per cycle while the queue has room; its results enter
// a four-entry queue at the same edge and leave it in order, one per cycle while
// out_ready is high. Outside passthrough a closed window gives two results, so
// with window_len of 0 or 1 the output port sets the pace. in_ready drops only
// when the queue holds more than two results. Reset clears the envelope state,
// the counters and the queue; no clearing pass is needed.
module min_max_envelope_decimator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [mme_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                event_req,
	input  logic                                start_req,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mme_pkg::COUNT_BITS-1:0]      x_coord,
	output logic signed [mme_pkg::SAMPLE_BITS-1:0] value,
	output logic                                event_mark,
	output logic                                last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mme_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [mme_pkg::DATA_BITS-1:0]       pwdata,
	output logic [mme_pkg::DATA_BITS-1:0]       prdata,
	output logic                                pready
);
	import mme_pkg::*;

	cfg_t    cfg;
	push_t   push;
	result_t head;
	logic    room;

	assign in_ready   = room;
	assign x_coord    = head.x_coord;
	assign value      = head.value;
	assign event_mark = head.event_mark;
	assign last       = head.last;

	mme_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mme_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.accept    (in_valid && room),
		.sample    (sample),
		.event_req (event_req),
		.start_req (start_req),
		.push      (push)
	);

	mme_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

endmodule
